// ===== src/fhc_pkg.sv =====
// Shared types and constants for the float/half conversion pipeline.
`default_nettype none

package fhc_pkg;

    // Direction code carried on tuser
    typedef enum logic
    {
        OP_F2H = 1'b0,
        OP_H2F = 1'b1
    } op_t;

    // Float field limits
    localparam logic [7:0]  F_SUB_MAX_EXP  = 8'd112;  // at or below: half subnormal
    localparam logic [7:0]  F_TINY_MAX_EXP = 8'd81;   // at or below: shifted out to zero
    localparam logic [7:0]  F_SUB_BIAS     = 8'd113;
    localparam logic [23:0] F_HIDDEN_ONE   = 24'h800000;

    // Half to float rebias, exponent difference placed at bit 23
    localparam logic [30:0] H_REBIAS       = 31'h38000000;
    localparam logic [9:0]  H_SUB_MAX      = 10'h3ff;
    localparam logic [3:0]  H_MANT_BITS    = 4'd10;

    // Decoded item after the first stage
    typedef struct packed
    {
        op_t         op;
        logic [1:0]  f_top;      // float bits 31..30
        logic        f_sub;
        logic        f_tiny;
        logic [4:0]  f_sh;
        logic [23:0] f_mant;     // mantissa with hidden one
        logic [13:0] f_pick;     // float bits 26..13
        logic        h_sign;
        logic [14:0] h_em;
        logic        h_norm;
        logic        h_zero;
        logic [3:0]  h_lz;       // left shift that brings the top one to bit 10
    } dec_t;

    // Item after the second stage
    typedef struct packed
    {
        op_t         op;
        logic [1:0]  sign;
        logic [30:0] mag;
    } mid_t;

endpackage

`default_nettype wire

// ===== src/fhc_decode.sv =====
// Field split, range checks and leading-zero count for one input beat.
`default_nettype none

module fhc_decode
(
    input  wire logic         op,
    input  wire logic [31:0]  value,
    output fhc_pkg::dec_t     dec
);

    logic [7:0] exp_f;
    logic [7:0] sh_full;
    logic [9:0] em_low;
    logic [3:0] top_pos;

    assign exp_f   = value[30:23];
    assign sh_full = fhc_pkg::F_SUB_BIAS - exp_f;
    assign em_low  = value[9:0];

    // Position of the highest set bit of a half subnormal mantissa
    always_comb
    begin
        top_pos = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (em_low[i])
            begin
                top_pos = 4'(i);
            end
        end
    end

    // Pack decoded fields
    always_comb
    begin
        dec.op     = fhc_pkg::op_t'(op);
        dec.f_top  = value[31:30];
        dec.f_sub  = (exp_f <= fhc_pkg::F_SUB_MAX_EXP);
        dec.f_tiny = (exp_f <= fhc_pkg::F_TINY_MAX_EXP);
        dec.f_sh   = sh_full[4:0];
        dec.f_mant = {1'b0, value[22:0]} | fhc_pkg::F_HIDDEN_ONE;
        dec.f_pick = value[26:13];
        dec.h_sign = value[15];
        dec.h_em   = value[14:0];
        dec.h_norm = (value[14:10] != 5'd0);
        dec.h_zero = (value[14:0] == 15'd0);
        dec.h_lz   = fhc_pkg::H_MANT_BITS - top_pos;
    end

endmodule

`default_nettype wire

// ===== src/float_half_conversion.sv =====
// Top level: three-stage float/half bit-pattern converter with stream ports.
`default_nettype none

// Converts one 32-bit word per beat, float to half or half to float as tuser
// selects. A beat passes through three registered stages: decode and
// leading-zero count, then the mantissa shift or rebias add, then the output
// register. One beat enters every cycle while the output is taken; each stage
// holds its beat under backpressure and frees as soon as its successor moves,
// so bubbles close up. Float to half truncates with no rounding, no overflow
// clamp and no infinity or NaN handling; half to float rebiases and
// normalizes subnormals.
module float_half_conversion
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  wire logic        s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] value_out
);

    fhc_pkg::dec_t dec_in;
    fhc_pkg::dec_t dec_reg;
    fhc_pkg::mid_t mid_next;
    fhc_pkg::mid_t mid_reg;
    logic [31:0]   out_next;
    logic [31:0]   out_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;

    logic [23:0] f_shifted;
    logic [7:0]  h_exp;
    logic [10:0] h_mshift;

    // Per-stage ready: a stage takes a beat when empty or when it moves on
    assign ready3 = !v3_reg || m_axis_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;

    // Stage 1: decode
    fhc_decode u_decode
    (
        .op    (s_axis_tuser),
        .value (s_axis_tdata),
        .dec   (dec_in)
    );

    // Stage 2: subnormal shift, rebias add or normalize
    assign f_shifted = dec_reg.f_mant >> dec_reg.f_sh;
    assign h_exp     = fhc_pkg::F_SUB_BIAS - {4'd0, dec_reg.h_lz};
    assign h_mshift  = {1'b0, dec_reg.h_em[9:0]} << dec_reg.h_lz;

    always_comb
    begin
        mid_next.op = dec_reg.op;
        unique case (dec_reg.op)
            fhc_pkg::OP_F2H:
            begin
                mid_next.sign = dec_reg.f_top;
                if (dec_reg.f_tiny)
                begin
                    mid_next.mag = 31'd0;
                end
                else if (dec_reg.f_sub)
                begin
                    mid_next.mag = {21'd0, f_shifted[22:13]};
                end
                else
                begin
                    mid_next.mag = {17'd0, dec_reg.f_pick};
                end
            end
            fhc_pkg::OP_H2F:
            begin
                mid_next.sign = {dec_reg.h_sign, 1'b0};
                if (dec_reg.h_zero)
                begin
                    mid_next.mag = 31'd0;
                end
                else if (dec_reg.h_norm)
                begin
                    mid_next.mag = {3'd0, dec_reg.h_em, 13'd0} + fhc_pkg::H_REBIAS;
                end
                else
                begin
                    mid_next.mag = {h_exp, h_mshift[9:0] & fhc_pkg::H_SUB_MAX, 13'd0};
                end
            end
            default:
            begin
                mid_next.sign = 2'd0;
                mid_next.mag  = 31'd0;
            end
        endcase
    end

    // Stage 3: assemble output word
    always_comb
    begin
        unique case (mid_reg.op)
            fhc_pkg::OP_F2H: out_next = {16'd0, mid_reg.sign, mid_reg.mag[13:0]};
            fhc_pkg::OP_H2F: out_next = {mid_reg.sign[1], mid_reg.mag};
            default:         out_next = 32'd0;
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ready1 && s_axis_tvalid)
        begin
            dec_reg <= dec_in;
        end
        if (ready2 && v1_reg)
        begin
            mid_reg <= mid_next;
        end
        if (ready3 && v2_reg)
        begin
            out_reg <= out_next;
        end
    end

    // A beat accepted at the input lands in stage 1
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted beat missing from stage 1");

    // Stage 1 beat moves to stage 2 when stage 2 frees
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && ready2) |=> v2_reg)
        else $error("stage 1 beat lost");

    // A stalled stage 2 keeps its beat
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> (v2_reg && $stable(mid_reg)))
        else $error("stage 2 beat changed under stall");

    // Half results have a clear upper word
    a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ready3 && mid_reg.op == fhc_pkg::OP_F2H)
            |=> (m_axis_tdata[31:16] == 16'd0))
        else $error("half result with upper bits set");

endmodule

`default_nettype wire

// ===== test/fhc_result_checker.sv =====
// Stream watcher for the float/half converter: predicts each output word and compares it.

module fhc_result_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  wire logic        s_axis_tuser,   // [0] op
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,   // [31:0] value_out
    output int               failures,
    output int               outstanding,
    output int               compared
);

    localparam int MAX_PRINTED = 30;

    // One accepted input beat and the word it must produce
    typedef struct
    {
        fhc_pkg::op_t op;
        logic [31:0]  word_in;
        logic [31:0]  word_out;
    } conversion_t;

    conversion_t pending_conversions[$];

    // Float to half: truncating, subnormal by shift, wrapping bit pick above
    function automatic logic [31:0] half_from_float(logic [31:0] word);
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [7:0]  shift;
        logic [15:0] half;
        expo = word[30:23];
        mant = {1'b1, word[22:0]};
        if (expo <= fhc_pkg::F_SUB_MAX_EXP)
        begin
            shift = fhc_pkg::F_SUB_BIAS - expo;
            // shift of a full word or more leaves nothing
            if (shift >= 8'd32)
                half = '0;
            else
                half = 16'((mant >> shift) >> 13);
        end
        else
        begin
            half = {2'b00, word[26:13]};
        end
        half[15:14] = half[15:14] | word[31:30];
        return {16'h0000, half};
    endfunction

    // Half to float: rebias normals, normalize subnormals, signed zero
    function automatic logic [31:0] float_from_half(logic [31:0] word);
        logic [14:0] em;
        logic [10:0] frac;
        int          lead;
        logic [31:0] flt;
        em  = word[14:0];
        flt = {word[15], 31'h0};
        if (em > 15'(fhc_pkg::H_SUB_MAX))
        begin
            flt[30:0] = (31'(em) << 13) + fhc_pkg::H_REBIAS;
        end
        else if (em != '0)
        begin
            frac = em[10:0];
            lead = 0;
            while (!frac[10])
            begin
                frac = frac << 1;
                lead++;
            end
            flt[30:23] = 8'(113 - lead);
            flt[22:13] = frac[9:0];
        end
        return flt;
    endfunction

    function automatic logic [31:0] predict_conversion(fhc_pkg::op_t op, logic [31:0] word);
        if (op == fhc_pkg::OP_H2F)
            return float_from_half(word);
        return half_from_float(word);
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Input beats queue expectations, output beats retire the oldest one
    always @(posedge clk)
    begin
        conversion_t item;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                item.op       = fhc_pkg::op_t'(s_axis_tuser);
                item.word_in  = s_axis_tdata;
                item.word_out = predict_conversion(item.op, s_axis_tdata);
                pending_conversions.push_back(item);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_conversions.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output beat %h", m_axis_tdata));
                end
                else
                begin
                    item = pending_conversions.pop_front();
                    compared++;
                    if (m_axis_tdata !== item.word_out)
                        report_mismatch($sformatf("%s in %h: value_out %h, want %h",
                                                  item.op.name(), item.word_in,
                                                  m_axis_tdata, item.word_out));
                end
            end
            outstanding = pending_conversions.size();
        end
    end

endmodule

// ===== test/float_half_conversion_tb.sv =====
// Testbench top for the float/half converter: stimulus, flow control and verdict.

module float_half_conversion_tb;

    localparam int RANDOM_BEATS = 925;
    localparam int LONG_HOLD    = 64;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_AT     = 600;
    localparam int TAIL_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value_in
    logic        s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] value_out

    int failures;
    int outstanding;
    int compared;
    int f2h_sent;
    int h2f_sent;
    int hold_requests;

    float_half_conversion uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fhc_result_checker conv_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .outstanding   (outstanding),
        .compared      (compared)
    );

    always #5 clk = ~clk;

    // Offer one beat and hold it until accepted
    task automatic offer_word(input fhc_pkg::op_t op, input logic [31:0] word);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == fhc_pkg::OP_H2F)
            h2f_sent++;
        else
            f2h_sent++;
    endtask

    // Sender gap with junk on the data lines
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom);
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        pause_sender(1);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Random operand, weighted toward the interesting exponent ranges
    function automatic logic [31:0] pick_operand(fhc_pkg::op_t op);
        logic [31:0] word;
        int          kind;
        word = $urandom;
        kind = $urandom_range(0, 9);
        if (op == fhc_pkg::OP_F2H)
        begin
            case (kind)
                0, 1, 2, 3: word[30:23] = 8'($urandom_range(113, 142));  // half normal range
                4, 5:       word[30:23] = 8'($urandom_range(82, 112));   // half subnormal
                6:          word[30:23] = 8'($urandom_range(0, 81));     // shifted out to zero
                7:          word[30:23] = 8'($urandom_range(143, 255));  // wrapping picks
                default:    ;
            endcase
        end
        else
        begin
            case (kind)
                0:          word[14:0] = '0;
                1, 2, 3:    word[14:0] = 15'($urandom_range(1, 16'h03ff));
                4, 5, 6, 7: word[14:10] = 5'($urandom_range(1, 30));
                8:          word[14:10] = 5'h1f;                         // inf / NaN
                default:    ;
            endcase
        end
        return word;
    endfunction

    // Receiver: ready pattern changes per stretch; long hold on request
    initial
    begin
        int mode;
        int span;
        int tick;
        int hold_seen;
        m_axis_tready = 1'b0;
        hold_seen     = 0;
        tick          = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_seen != hold_requests)
                begin
                    hold_seen = hold_requests;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom);
                        2:       m_axis_tready <= (tick % 3) == 0;
                        default: m_axis_tready <= $urandom_range(0, 7) != 0;
                    endcase
                end
            end
        end
    end

    // Run guard
    initial
    begin
        #2_000_000;
        $display("float_half_conversion verification failed");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        logic [31:0] f2h_edges[$];
        logic [31:0] h2f_edges[$];
        int          done;
        int          burst;
        bit          hold_issued;
        bit          drained;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        f2h_sent      = 0;
        h2f_sent      = 0;
        hold_requests = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zeros, boundaries, tiny exponents, wrap, inf/NaN, ignored upper bits
        f2h_edges = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'h477f_e000,
                      32'h3880_0000, 32'h3800_0000, 32'h387f_ffff, 32'h2900_0000,
                      32'h2880_0000, 32'ha8ff_ffff, 32'h7f80_0000, 32'h7fc0_0000,
                      32'hffff_ffff, 32'hc780_0000};
        h2f_edges = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03ff,
                      32'h0000_0200, 32'h0000_0400, 32'h0000_7bff, 32'h0000_7c00,
                      32'h0000_7e00, 32'h0000_ffff, 32'hdead_3c00};
        foreach (f2h_edges[i])
            offer_word(fhc_pkg::OP_F2H, f2h_edges[i]);
        foreach (h2f_edges[i])
            offer_word(fhc_pkg::OP_H2F, h2f_edges[i]);
        wait_for_drain();

        // Random bursts with gaps; one long output hold, one full drain
        done        = 0;
        hold_issued = 1'b0;
        drained     = 1'b0;
        while (done < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 40);
            if (!hold_issued && done >= HOLD_AT)
            begin
                hold_issued = 1'b1;
                hold_requests++;
                burst = 40;
            end
            if (!drained && done >= DRAIN_AT)
            begin
                drained = 1'b1;
                wait_for_drain();
            end
            repeat (burst)
            begin
                fhc_pkg::op_t op;
                if (done < RANDOM_BEATS)
                begin
                    op = fhc_pkg::op_t'($urandom_range(0, 1));
                    offer_word(op, pick_operand(op));
                    done++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(0, 6));
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d float-to-half and %0d half-to-float beats, %0d outputs compared,",
                 f2h_sent, h2f_sent, compared);
        $display("with subnormal, tiny, wrapping and inf/NaN operands under random stalls.");
        if (failures == 0)
            $display("float_half_conversion verification clean");
        else
            $display("float_half_conversion verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fhc_pkg.sv
src/fhc_decode.sv
src/float_half_conversion.sv
test/fhc_result_checker.sv
test/float_half_conversion_tb.sv
